@@ hw/rtl/pmsfp_pkg.sv @@
package pmsfp_pkg;

    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned IDX_W   = 7;
    localparam int unsigned END_W   = 5;
    localparam int unsigned TYPE_W  = 2;
    localparam int unsigned PM_W    = 16;
    localparam int unsigned STORE_N = 8;
    localparam int unsigned SADDR_W = 3;

    // frame sync bytes
    localparam logic [BYTE_W-1:0] HDR_START  = 8'h42;
    localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h4D;

    // valid length words
    localparam logic [PM_W-1:0] LEN_SHORT = 16'h0014;
    localparam logic [PM_W-1:0] LEN_LONG  = 16'h001C;

    // sensor type codes
    localparam logic [TYPE_W-1:0] TYPE_NONE  = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_SHORT = 2'd1;
    localparam logic [TYPE_W-1:0] TYPE_LONG  = 2'd2;

    // frame positions
    localparam logic [IDX_W-1:0] STORE_FIRST = 7'd2;
    localparam logic [IDX_W-1:0] STORE_LAST  = 7'd9;
    localparam logic [IDX_W-1:0] LEN_INDEX   = 7'd3;

    // end index = length + 3
    localparam logic [END_W-1:0] END_NONE  = 5'd0;
    localparam logic [END_W-1:0] END_SHORT = 5'd23;
    localparam logic [END_W-1:0] END_LONG  = 5'd31;

    typedef struct packed {
        logic [TYPE_W-1:0] sensor_type;
        logic [PM_W-1:0]   pm_small;
        logic [PM_W-1:0]   pm_fine;
        logic [PM_W-1:0]   pm_coarse;
        logic              frame_done;
    } pmsfp_result_t;

    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } pmsfp_stage_t;

    typedef struct packed {
        logic [IDX_W-1:0] byte_index;
        logic [END_W-1:0] end_index;
    } pmsfp_track_t;

endpackage

@@ hw/rtl/pmsfp_byte_if.sv @@
interface pmsfp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

@@ hw/rtl/pmsfp_result_if.sv @@
interface pmsfp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  sensor_type;
    logic [15:0] pm_small;
    logic [15:0] pm_fine;
    logic [15:0] pm_coarse;
    logic        frame_done;

    modport source (
        output valid, output sensor_type, output pm_small, output pm_fine,
        output pm_coarse, output frame_done, input ready
    );
    modport sink (
        input valid, input sensor_type, input pm_small, input pm_fine,
        input pm_coarse, input frame_done, output ready
    );
endinterface

@@ hw/rtl/pmsfp_in_reg.sv @@
module pmsfp_in_reg
    import pmsfp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    pmsfp_byte_if.sink   rx,
    input  logic         advance,
    output pmsfp_stage_t stage
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] byte_reg;
    logic              take;

    assign rx.ready = !valid_reg || advance;
    assign take     = rx.valid && rx.ready;

    always_comb
    begin
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= rx.rx_byte;
        end
    end

    assign stage.valid   = valid_reg;
    assign stage.rx_byte = byte_reg;

endmodule

@@ hw/rtl/pmsfp_parse.sv @@
module pmsfp_parse
    import pmsfp_pkg::*;
#(
    parameter int unsigned INDEX_LIMIT = 100
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [BYTE_W-1:0] rx_byte,
    output pmsfp_result_t     result,
    output pmsfp_track_t      track
);

    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [END_W-1:0]  end_reg;
    logic [END_W-1:0]  end_next;
    logic [TYPE_W-1:0] type_reg;
    logic [TYPE_W-1:0] type_next;
    logic [PM_W-1:0]   small_reg;
    logic [PM_W-1:0]   small_next;
    logic [PM_W-1:0]   fine_reg;
    logic [PM_W-1:0]   fine_next;
    logic [PM_W-1:0]   coarse_reg;
    logic [PM_W-1:0]   coarse_next;
    logic [BYTE_W-1:0] store_reg [STORE_N];
    logic              store_wr;
    logic [SADDR_W-1:0] store_addr;
    logic [PM_W-1:0]   len_word;
    logic              done;

    always_comb
    begin
        if (rx_byte == HDR_START)
        begin
            idx_next = '0;
        end
        else if (rx_byte == HDR_SECOND)
        begin
            idx_next = IDX_W'(1);
        end
        else if (idx_reg < IDX_W'(INDEX_LIMIT))
        begin
            idx_next = idx_reg + IDX_W'(1);
        end
        else
        begin
            idx_next = idx_reg;
        end
    end

    assign store_wr   = (idx_next >= STORE_FIRST) && (idx_next <= STORE_LAST);
    assign store_addr = SADDR_W'(idx_next - STORE_FIRST);

    // low length byte is the one arriving now
    assign len_word = {store_reg[0], rx_byte};

    always_comb
    begin
        end_next    = (rx_byte == HDR_START) ? END_NONE : end_reg;
        type_next   = type_reg;
        small_next  = small_reg;
        fine_next   = fine_reg;
        coarse_next = coarse_reg;
        done        = 1'b0;
        if (idx_next == LEN_INDEX)
        begin
            if (len_word == LEN_SHORT)
            begin
                type_next = TYPE_SHORT;
                end_next  = END_SHORT;
            end
            else if (len_word == LEN_LONG)
            begin
                type_next = TYPE_LONG;
                end_next  = END_LONG;
            end
            else
            begin
                type_next   = TYPE_NONE;
                end_next    = END_NONE;
                small_next  = '0;
                fine_next   = '0;
                coarse_next = '0;
            end
        end
        // end index lies past the stored bytes, so the store is settled here
        if ((end_next != END_NONE) && (idx_next == {{(IDX_W-END_W){1'b0}}, end_next}))
        begin
            small_next  = {store_reg[2], store_reg[3]};
            fine_next   = {store_reg[4], store_reg[5]};
            coarse_next = {store_reg[6], store_reg[7]};
            done        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg    <= '0;
            end_reg    <= END_NONE;
            type_reg   <= TYPE_NONE;
            small_reg  <= '0;
            fine_reg   <= '0;
            coarse_reg <= '0;
            for (int i = 0; i < STORE_N; i++)
            begin
                store_reg[i] <= '0;
            end
        end
        else if (step)
        begin
            idx_reg    <= idx_next;
            end_reg    <= end_next;
            type_reg   <= type_next;
            small_reg  <= small_next;
            fine_reg   <= fine_next;
            coarse_reg <= coarse_next;
            if (store_wr)
            begin
                store_reg[store_addr] <= rx_byte;
            end
        end
    end

    assign result.sensor_type = type_next;
    assign result.pm_small    = small_next;
    assign result.pm_fine     = fine_next;
    assign result.pm_coarse   = coarse_next;
    assign result.frame_done  = done;

    assign track.byte_index = idx_reg;
    assign track.end_index  = end_reg;

endmodule

@@ hw/rtl/pmsfp_out_reg.sv @@
module pmsfp_out_reg
    import pmsfp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  pmsfp_result_t   result,
    output logic            can_load,
    pmsfp_result_if.source  res
);

    logic          valid_reg;
    logic          valid_next;
    pmsfp_result_t data_reg;

    assign can_load = !valid_reg || res.ready;

    always_comb
    begin
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (res.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

    assign res.valid       = valid_reg;
    assign res.sensor_type = data_reg.sensor_type;
    assign res.pm_small    = data_reg.pm_small;
    assign res.pm_fine     = data_reg.pm_fine;
    assign res.pm_coarse   = data_reg.pm_coarse;
    assign res.frame_done  = data_reg.frame_done;

endmodule

@@ hw/rtl/particulate_sensor_frame_parser_core.sv @@
// Particulate sensor frame parser.
// rx  (sink):   one received serial byte per word, valid/ready handshake.
// res (source): one result word per input byte: sensor type, the latched
//               PM1.0 / PM2.5 / PM10 readings, and frame_done when this
//               byte closed a frame and the readings were just latched.
// Throughput: one byte per cycle while the output is not stalled. The byte
//   is held in the input register, then the parse logic updates the frame
//   state and loads the output register once that register can take it.
// Stall: when res.ready is low the output register holds its word; the
//   input register takes one more byte, then rx.ready drops until the
//   output drains. Nothing is dropped or repeated.
// Reset: both registers empty; index, end index, type, byte store and
//   readings all zero. No clearing pass, the block is ready at once.
// Frame state: 0x42 restarts the index, 0x4D sets it to 1; the length word
//   at index 3 picks the type and end index (23 or 31); the index
//   saturates at INDEX_LIMIT.
module particulate_sensor_frame_parser_core
    import pmsfp_pkg::*;
#(
    parameter int unsigned INDEX_LIMIT = 100
)
(
    input  logic           clk,
    input  logic           rst_n,
    pmsfp_byte_if.sink     rx,
    pmsfp_result_if.source res
);

    pmsfp_stage_t  stage;
    pmsfp_result_t result;
    pmsfp_track_t  track;
    logic          can_load;
    logic          step;

    // the input register moves on whenever the output register can take it
    assign step = stage.valid && can_load;

    pmsfp_in_reg u_in_reg (
        .clk     (clk),
        .rst_n   (rst_n),
        .rx      (rx),
        .advance (can_load),
        .stage   (stage)
    );

    pmsfp_parse #(
        .INDEX_LIMIT (INDEX_LIMIT)
    ) u_parse (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .rx_byte (stage.rx_byte),
        .result  (result),
        .track   (track)
    );

    pmsfp_out_reg u_out_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (step),
        .result   (result),
        .can_load (can_load),
        .res      (res)
    );

    // a completed frame always carries a known type
    a_done_has_type: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.frame_done |-> res.sensor_type != TYPE_NONE)
        else $error("frame_done with unknown sensor type");

    // index never passes its saturation point
    a_index_limit: assert property (@(posedge clk) disable iff (!rst_n)
        track.byte_index <= IDX_W'(INDEX_LIMIT))
        else $error("byte index beyond limit");

    // end index only ever holds none or one of the two frame ends
    a_end_index: assert property (@(posedge clk) disable iff (!rst_n)
        track.end_index == END_NONE || track.end_index == END_SHORT
        || track.end_index == END_LONG)
        else $error("bad frame end index");

    // a held byte is not consumed while the output is stalled
    a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
        stage.valid && !can_load |=> stage.valid && $stable(stage.rx_byte))
        else $error("staged byte lost during stall");

endmodule
